// ----- rtl/rpp_pkg.sv -----
// Shared types and constants for the RAMDAC palette processor port.
package rpp_pkg;

    // Storage sizes.
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = $clog2(PAL_DEPTH);
    localparam int OVL_DEPTH  = 4;
    localparam int OVL_AW     = $clog2(OVL_DEPTH);
    localparam int ENTRY_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int PHASE_W    = 2;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;

    // Colour byte phases.
    localparam logic [PHASE_W-1:0] PH_RED   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_GREEN = 2'd1;
    localparam logic [PHASE_W-1:0] PH_BLUE  = 2'd2;

    // Control register addresses and the last overlay address.
    localparam logic [BYTE_W-1:0] CTL_READ_MASK  = 8'd4;
    localparam logic [BYTE_W-1:0] CTL_BLINK_MASK = 8'd5;
    localparam logic [BYTE_W-1:0] CTL_COMMAND    = 8'd6;
    localparam logic [BYTE_W-1:0] CTL_TEST       = 8'd7;
    localparam logic [BYTE_W-1:0] OVL_LAST_ADDR  = 8'd3;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        PORT_ADDRESS = 2'd0,
        PORT_PALETTE = 2'd1,
        PORT_OVERLAY = 2'd2,
        PORT_CONTROL = 2'd3
    } t_port;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the item and start the palette read
        logic exec;     // update state and load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } t_sts;

endpackage

// ----- rtl/rpp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rpp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rpp_ctrl.sv -----
// Controller state machine: takes one item, then executes it once the output is free.
module rpp_ctrl
    import rpp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rpp_datapath.sv -----
// Datapath: address, phase, pending bytes, palette RAM, overlay and control registers.
module rpp_datapath
    import rpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [IN_USER_W-1:0]  i_in_user,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    // Latched item.
    t_op               r_op;
    t_port             r_port;
    logic [BYTE_W-1:0] r_wdata;

    // Architectural state.
    logic [BYTE_W-1:0]  r_addr;
    logic [PHASE_W-1:0] r_phase;
    logic [BYTE_W-1:0]  r_pend [3];
    logic [ENTRY_W-1:0] r_ovl [OVL_DEPTH];
    logic [PAL_DEPTH-1:0] r_pal_valid;
    logic [BYTE_W-1:0]  r_read_mask;
    logic [BYTE_W-1:0]  r_blink_mask;
    logic [BYTE_W-1:0]  r_command;
    logic [BYTE_W-1:0]  r_test;

    // Output register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Combinational results of the execute step.
    logic [ENTRY_W-1:0] ram_q;
    logic [ENTRY_W-1:0] pal_entry;
    logic [ENTRY_W-1:0] cur_entry;
    logic [ENTRY_W-1:0] new_entry;
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] n_phase;
    logic [BYTE_W-1:0]  n_addr;
    logic [BYTE_W-1:0]  result;
    logic [BYTE_W-1:0]  colour_byte;
    logic               writing;
    logic               colour_port;
    logic               is_blue;
    logic               pal_we;
    logic               ovl_we;

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Palette storage; the read is issued when the item is taken.
    rpp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_addr),
        .i_wdata (new_entry),
        .i_re    (i_cmd.capture),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    // Entry selection and colour byte extraction.
    always_comb begin
        writing     = (r_op == OP_WRITE);
        colour_port = (r_port == PORT_PALETTE) || (r_port == PORT_OVERLAY);
        phase       = (r_phase > PH_BLUE) ? PH_RED : r_phase;
        is_blue     = (phase == PH_BLUE);
        pal_entry   = r_pal_valid[r_addr] ? ram_q : '0;
        cur_entry   = (r_port == PORT_OVERLAY) ? r_ovl[r_addr[OVL_AW-1:0]] : pal_entry;
        new_entry   = {r_pend[0], r_pend[1], r_wdata};
        unique case (phase)
            PH_RED:   colour_byte = cur_entry[23:16];
            PH_GREEN: colour_byte = cur_entry[15:8];
            default:  colour_byte = cur_entry[7:0];
        endcase
    end

    // Result, next phase and next address for the latched item.
    always_comb begin
        result  = '0;
        n_phase = r_phase;
        n_addr  = r_addr;
        pal_we  = 1'b0;
        ovl_we  = 1'b0;
        unique case (r_port)
            PORT_ADDRESS: begin
                result  = r_addr;
                n_phase = PH_RED;
                if (writing) begin
                    n_addr = r_wdata;
                end
            end
            PORT_PALETTE, PORT_OVERLAY: begin
                result = colour_byte;
                if (is_blue) begin
                    n_phase = PH_RED;
                    if ((r_port == PORT_OVERLAY) && (r_addr == OVL_LAST_ADDR)) begin
                        n_addr = CTL_READ_MASK;
                    end else begin
                        n_addr = r_addr + 8'd1;
                    end
                    pal_we = i_cmd.exec && writing && (r_port == PORT_PALETTE);
                    ovl_we = i_cmd.exec && writing && (r_port == PORT_OVERLAY);
                end else begin
                    n_phase = phase + 2'd1;
                end
            end
            default: begin
                unique case (r_addr)
                    CTL_READ_MASK:  result = r_read_mask;
                    CTL_BLINK_MASK: result = r_blink_mask;
                    CTL_COMMAND:    result = r_command;
                    CTL_TEST:       result = r_test;
                    default:        result = '0;
                endcase
            end
        endcase
        if (writing) begin
            result = '0;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_in_user[0]);
            r_port  <= t_port'(i_in_user[2:1]);
            r_wdata <= i_in_data;
        end
    end

    // State update on execute.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_phase      <= PH_RED;
            r_pal_valid  <= '0;
            r_read_mask  <= '0;
            r_blink_mask <= '0;
            r_command    <= '0;
            r_test       <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pend[i] <= '0;
            end
            for (int i = 0; i < OVL_DEPTH; i++) begin
                r_ovl[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_addr  <= n_addr;
            r_phase <= n_phase;
            if (writing && colour_port) begin
                r_pend[phase] <= r_wdata;
            end
            if (pal_we) begin
                r_pal_valid[r_addr] <= 1'b1;
            end
            if (ovl_we) begin
                r_ovl[r_addr[OVL_AW-1:0]] <= new_entry;
            end
            if (writing && (r_port == PORT_CONTROL)) begin
                unique case (r_addr)
                    CTL_READ_MASK:  r_read_mask  <= r_wdata;
                    CTL_BLINK_MASK: r_blink_mask <= r_wdata;
                    CTL_COMMAND:    r_command    <= r_wdata;
                    CTL_TEST:       r_test       <= r_wdata;
                    default:        ;
                endcase
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= {{(OUT_DATA_W - BYTE_W - PHASE_W){1'b0}}, n_phase, result};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/ramdac_palette_port.sv -----
// Top level of the RAMDAC palette processor port.
//
// Each item on the slave stream is one bus access: s_tuser carries the opcode
// (read or write) and the port (address, palette, overlay, control), s_tdata
// the write byte. Each access returns exactly one item on the master stream
// with the read byte (zero for writes) and the colour byte counter after it.
// An item is taken in the idle state and executed in the execute state once
// the output register is free, when the palette RAM's registered read data is
// available; the block takes no new item until the last one has executed.
// The result is loaded into the output register when the item executes.
// If the receiver stalls, the result waits in the output register and the
// block holds the next item in its execute step until that register frees.
// Reset clears the address, byte counter, pending bytes, overlay and control
// registers and marks every palette entry as zero, with no clearing pass.
module ramdac_palette_port
    import rpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] write_data
    input  logic [IN_USER_W-1:0]  s_tuser,   // [0] opcode, [2:1] port_select
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [7:0] read_data, [9:8] byte_phase
);

    t_cmd cmd;
    t_sts sts;

    // Sequencing of each access.
    rpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Register file, palette storage and result register.
    rpp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_tdata),
        .i_in_user   (s_tuser),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (m_tdata)
    );

endmodule

// ----- verif/tb_ramdac_palette_port.sv -----
// Self-checking testbench for the RAMDAC palette processor port.
module tb_ramdac_palette_port;
    timeunit 1ns;
    timeprecision 1ps;
    import rpp_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_DIRECTED = 27;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        logic [PHASE_W-1:0] byte_phase;
    } t_readback;

    // One row of the directed table; the result is typed in only where has_want is set.
    typedef struct packed {
        t_op               op;
        t_port             port;
        logic [BYTE_W-1:0] data;
        logic              has_want;
        t_readback         want;
    } t_access_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [7:0] write_data
    logic [IN_USER_W-1:0]  s_tuser;   // [0] opcode, [2:1] port_select
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [7:0] read_data, [9:8] byte_phase

    // Shadow copy of the block's state, kept by the predictor.
    logic [BYTE_W-1:0]  mdl_addr;
    logic [PHASE_W-1:0] mdl_phase;
    logic [BYTE_W-1:0]  mdl_pending [3];
    logic [ENTRY_W-1:0] mdl_palette [PAL_DEPTH];
    logic [ENTRY_W-1:0] mdl_overlay [OVL_DEPTH];
    logic [BYTE_W-1:0]  mdl_ctl [4];

    t_readback exp_readback_q [$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_idle_pct  = 0;
    int        quiet_cycles   = 0;

    // Directed accesses: wrap of the address, mixed colour reads and writes,
    // overlay index and jump, control registers and unmapped control reads.
    t_access_row access_table [NUM_DIRECTED] = '{
        '{OP_READ,  PORT_ADDRESS, 8'h00, 1'b1, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_PALETTE, 8'h00, 1'b1, '{8'h00, PH_GREEN}},
        '{OP_WRITE, PORT_ADDRESS, 8'hFF, 1'b1, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_PALETTE, 8'hFF, 1'b1, '{8'h00, PH_GREEN}},
        '{OP_WRITE, PORT_PALETTE, 8'h00, 1'b1, '{8'h00, PH_BLUE}},
        '{OP_WRITE, PORT_PALETTE, 8'hA5, 1'b1, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_ADDRESS, 8'hFF, 1'b1, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_ADDRESS, 8'hFF, 1'b0, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_PALETTE, 8'h00, 1'b0, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_PALETTE, 8'h00, 1'b0, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_PALETTE, 8'h00, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_ADDRESS, 8'h43, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_OVERLAY, 8'h12, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_OVERLAY, 8'h34, 1'b0, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_OVERLAY, 8'hFF, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_ADDRESS, 8'h03, 1'b0, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_OVERLAY, 8'h00, 1'b0, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_OVERLAY, 8'h00, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_OVERLAY, 8'h56, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_CONTROL, 8'h80, 1'b0, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_CONTROL, 8'h00, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_ADDRESS, 8'h07, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_CONTROL, 8'hFF, 1'b0, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_CONTROL, 8'h00, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_ADDRESS, 8'h00, 1'b0, '{8'h00, PH_RED}},
        '{OP_WRITE, PORT_CONTROL, 8'h55, 1'b0, '{8'h00, PH_RED}},
        '{OP_READ,  PORT_CONTROL, 8'h00, 1'b1, '{8'h00, PH_RED}}
    };

    ramdac_palette_port u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation; the first rising edge comes half a period in.
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Works out the result of one bus access and updates the shadow state.
    task automatic predict_bus_access(input t_op op, input t_port port,
                                      input logic [BYTE_W-1:0] data,
                                      output t_readback res);
        logic [BYTE_W-1:0]  rd;
        logic [PHASE_W-1:0] ph;
        logic [ENTRY_W-1:0] entry;
        logic [OVL_AW-1:0]  ovl_idx;
        logic [1:0]         ctl_idx;
        rd = '0;
        case (port)
            PORT_ADDRESS: begin
                if (op == OP_WRITE) begin
                    mdl_addr = data;
                end else begin
                    rd = mdl_addr;
                end
                mdl_phase = PH_RED;
            end
            PORT_PALETTE, PORT_OVERLAY: begin
                ph      = (mdl_phase > PH_BLUE) ? PH_RED : mdl_phase;
                ovl_idx = mdl_addr[OVL_AW-1:0];
                entry   = (port == PORT_OVERLAY) ? mdl_overlay[ovl_idx] : mdl_palette[mdl_addr];
                if (op == OP_WRITE) begin
                    mdl_pending[ph] = data;
                end else begin
                    rd = BYTE_W'(entry >> (8 * (2 - ph)));
                end
                if (ph != PH_BLUE) begin
                    mdl_phase = ph + 1'b1;
                end else begin
                    // Blue byte: commit on a write, then step the address.
                    mdl_phase = PH_RED;
                    if (op == OP_WRITE) begin
                        entry = {mdl_pending[0], mdl_pending[1], mdl_pending[2]};
                        if (port == PORT_OVERLAY) begin
                            mdl_overlay[ovl_idx] = entry;
                        end else begin
                            mdl_palette[mdl_addr] = entry;
                        end
                    end
                    if (port == PORT_OVERLAY && mdl_addr == OVL_LAST_ADDR) begin
                        mdl_addr = CTL_READ_MASK;
                    end else begin
                        mdl_addr = mdl_addr + 1'b1;
                    end
                end
            end
            default: begin
                // Only addresses 4 to 7 reach a control register.
                if (mdl_addr >= CTL_READ_MASK && mdl_addr <= CTL_TEST) begin
                    ctl_idx = 2'(mdl_addr - CTL_READ_MASK);
                    if (op == OP_WRITE) begin
                        mdl_ctl[ctl_idx] = data;
                    end else begin
                        rd = mdl_ctl[ctl_idx];
                    end
                end
            end
        endcase
        if (op == OP_WRITE) begin
            rd = '0;
        end
        res.read_data  = rd;
        res.byte_phase = mdl_phase;
    endtask

    // Offers one item, with random idle cycles first, and waits until it is taken.
    task automatic send_access(input t_op op, input t_port port, input logic [BYTE_W-1:0] data,
                               input logic has_want, input t_readback want);
        t_readback predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {port, op};
        s_tdata  <= data;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        predict_bus_access(op, port, data, predicted);
        exp_readback_q.push_back(has_want ? want : predicted);
    endtask

    // Random traffic: mostly address setups followed by colour or control
    // accesses, with some single accesses of any kind in between.
    task automatic run_random_traffic(input int num_items);
        int    sent;
        int    kind;
        int    mode;
        int    runs;
        t_port colour_port;
        t_op   op;
        sent = 0;
        while (sent < num_items) begin
            kind = $urandom_range(9);
            if (kind <= 3) begin
                // Colour burst, mostly starting from a fresh address.
                if ($urandom_range(3) != 0) begin
                    case ($urandom_range(3))
                        0: send_access(OP_WRITE, PORT_ADDRESS, 8'($urandom_range(0, 7)),
                                       1'b0, '0);
                        1: send_access(OP_WRITE, PORT_ADDRESS, 8'($urandom_range(248, 255)),
                                       1'b0, '0);
                        default: send_access(OP_WRITE, PORT_ADDRESS, 8'($urandom_range(255)),
                                             1'b0, '0);
                    endcase
                    sent++;
                end
                colour_port = ($urandom_range(2) == 0) ? PORT_OVERLAY : PORT_PALETTE;
                runs = $urandom_range(1, 4);
                repeat (runs) begin
                    mode = $urandom_range(3);
                    repeat (3) begin
                        case (mode)
                            1: op = OP_READ;
                            2: op = t_op'($urandom_range(1));
                            default: op = OP_WRITE;
                        endcase
                        send_access(op, colour_port, 8'($urandom_range(255)), 1'b0, '0);
                        sent++;
                    end
                end
            end else if (kind <= 5) begin
                // Control register accesses.
                if ($urandom_range(3) != 0) begin
                    send_access(OP_WRITE, PORT_ADDRESS, 8'($urandom_range(4, 7)), 1'b0, '0);
                end else begin
                    send_access(OP_WRITE, PORT_ADDRESS, 8'($urandom_range(255)), 1'b0, '0);
                end
                sent++;
                runs = $urandom_range(1, 3);
                repeat (runs) begin
                    send_access(t_op'($urandom_range(1)), PORT_CONTROL,
                                8'($urandom_range(255)), 1'b0, '0);
                    sent++;
                end
            end else if (kind == 6) begin
                send_access(OP_READ, PORT_ADDRESS, 8'($urandom_range(255)), 1'b0, '0);
                sent++;
            end else begin
                // Any single access, which may break a colour in half.
                send_access(t_op'($urandom_range(1)), t_port'($urandom_range(3)),
                            8'($urandom_range(255)), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checking and the stall watchdog.
    always @(posedge i_clk) begin
        t_readback got;
        t_readback want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.read_data  = m_tdata[7:0];
                got.byte_phase = m_tdata[9:8];
                if (exp_readback_q.size() == 0) begin
                    report_mismatch("result with nothing expected", int'(m_tdata), 0);
                end else begin
                    want = exp_readback_q.pop_front();
                    if (got.read_data !== want.read_data) begin
                        report_mismatch("read_data", int'(got.read_data),
                                        int'(want.read_data));
                    end
                    if (got.byte_phase !== want.byte_phase) begin
                        report_mismatch("byte_phase", int'(got.byte_phase),
                                        int'(want.byte_phase));
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Reset, stimulus and end of run.
    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        mdl_addr  = '0;
        mdl_phase = PH_RED;
        for (int i = 0; i < 3; i++) begin
            mdl_pending[i] = '0;
        end
        for (int i = 0; i < PAL_DEPTH; i++) begin
            mdl_palette[i] = '0;
        end
        for (int i = 0; i < OVL_DEPTH; i++) begin
            mdl_overlay[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            mdl_ctl[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 17;
        recv_idle_pct = 46;
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_access(access_table[i].op, access_table[i].port, access_table[i].data,
                        access_table[i].has_want, access_table[i].want);
        end
        run_random_traffic(274);

        // The other way round.
        send_idle_pct = 46;
        recv_idle_pct = 17;
        run_random_traffic(274);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(275);
        s_tvalid <= 1'b0;

        while (exp_readback_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rpp_pkg.sv
rtl/rpp_ram.sv
rtl/rpp_ctrl.sv
rtl/rpp_datapath.sv
rtl/ramdac_palette_port.sv
verif/tb_ramdac_palette_port.sv
